// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/ssfl_pkg.sv
// ----------------------------------------------------------------------------
// Segregated free list package
// Operation codes and sequencer state encoding.
// ----------------------------------------------------------------------------
package ssfl_pkg;

	typedef enum logic [1:0] {
		OP_FREE  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [9:0] {
		ST_CLEAR      = 10'b00_0000_0001,
		ST_IDLE       = 10'b00_0000_0010,
		ST_EXEC       = 10'b00_0000_0100,
		ST_RD_WAIT    = 10'b00_0000_1000,
		ST_FREE_HEAD  = 10'b00_0001_0000,
		ST_FREE_ZERO  = 10'b00_0010_0000,
		ST_ALLOC_HEAD = 10'b00_0100_0000,
		ST_ALLOC_LINK = 10'b00_1000_0000,
		ST_ALLOC_CLR  = 10'b01_0000_0000,
		ST_ALLOC_SCAN = 10'b10_0000_0000
	} state_t;

endpackage

// File: rtl/ssfl_ram.sv
// ----------------------------------------------------------------------------
// Single-port RAM
// One address per cycle, synchronous write, registered read data.
// ----------------------------------------------------------------------------
module ssfl_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/size_segregated_free_list.sv
// ----------------------------------------------------------------------------
// Size-segregated free list allocator
// Operations are write, read, free and allocate; allocate may miss, and free
// or allocate may fault. Busy is high from transfer until done.
// Rate is set by the single word RAM port walking the block one word a cycle.
// After reset a clearing pass zeroes all words and list heads while busy
// is high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module size_segregated_free_list #(
	parameter int ADDR_BITS = 12,
	parameter int MAX_BLOCK = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic [ADDR_BITS-1:0]                address,
	input  logic [$clog2(MAX_BLOCK+1)-1:0]      block_size,
	input  logic signed [WORD_BITS-1:0]         write_data,
	output logic                                done,
	output logic [ADDR_BITS-1:0]                block_address,
	output logic                                hit,
	output logic                                fault,
	output logic signed [WORD_BITS-1:0]         read_data
);

	localparam int MEM_DEPTH = 1 << ADDR_BITS;
	localparam int SIZE_BITS = $clog2(MAX_BLOCK + 1);
	localparam int SUM_BITS  = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;
	localparam int CLR_LEN   = (MEM_DEPTH > MAX_BLOCK + 1) ? MEM_DEPTH : MAX_BLOCK + 1;
	localparam int CLR_BITS  = $clog2(CLR_LEN) + 1;

	function automatic logic fits(input logic [ADDR_BITS-1:0] a, input logic [SIZE_BITS-1:0] s);
		return (SUM_BITS'(a) + SUM_BITS'(s)) <= SUM_BITS'(MEM_DEPTH);
	endfunction

	ssfl_pkg::state_t state_q;
	ssfl_pkg::op_t    op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [WORD_BITS-1:0] data_q;
	logic [ADDR_BITS-1:0] ptr_q;
	logic [ADDR_BITS-1:0] blk_q;
	logic [SIZE_BITS-1:0] cnt_q;
	logic [CLR_BITS-1:0]  clr_q;
	logic                 chk_q;
	logic                 flt_q;

	logic                 done_q;
	logic [ADDR_BITS-1:0] blk_out_q;
	logic                 hit_q;
	logic                 fault_q;
	logic [WORD_BITS-1:0] rd_out_q;

	logic [ADDR_BITS-1:0] m_addr;
	logic                 m_we;
	logic                 m_re;
	logic [WORD_BITS-1:0] m_wdata;
	logic [WORD_BITS-1:0] word_rd;
	logic [SIZE_BITS-1:0] h_idx;
	logic                 h_we;
	logic                 h_re;
	logic [ADDR_BITS-1:0] h_wdata;
	logic [ADDR_BITS-1:0] head_rd;

	logic size_good;
	logic free_good;
	logic head_fits;
	logic scan_flt;

	assign size_good = (size_q >= SIZE_BITS'(2)) && (size_q <= SIZE_BITS'(MAX_BLOCK));
	assign free_good = size_good && (addr_q != '0) && fits(addr_q, size_q);
	assign head_fits = fits(head_rd, size_q);
	assign scan_flt  = chk_q && (word_rd != '0);

	ssfl_ram #(
		.DEPTH(MEM_DEPTH),
		.WIDTH(WORD_BITS)
	) u_words (
		.clk  (clk),
		.addr (m_addr),
		.we   (m_we),
		.wdata(m_wdata),
		.re   (m_re),
		.rdata(word_rd)
	);

	ssfl_ram #(
		.DEPTH(MAX_BLOCK + 1),
		.WIDTH(ADDR_BITS)
	) u_heads (
		.clk  (clk),
		.addr (h_idx),
		.we   (h_we),
		.wdata(h_wdata),
		.re   (h_re),
		.rdata(head_rd)
	);

	always_comb begin
		m_addr  = ptr_q;
		m_we    = 1'b0;
		m_re    = 1'b0;
		m_wdata = '0;
		h_idx   = size_q;
		h_we    = 1'b0;
		h_re    = 1'b0;
		h_wdata = '0;
		unique case (state_q)
			ssfl_pkg::ST_CLEAR: begin
				m_addr = clr_q[ADDR_BITS-1:0];
				m_we   = clr_q < CLR_BITS'(MEM_DEPTH);
				h_idx  = clr_q[SIZE_BITS-1:0];
				h_we   = clr_q <= CLR_BITS'(MAX_BLOCK);
			end
			ssfl_pkg::ST_EXEC: begin
				case (op_q)
					ssfl_pkg::OP_WRITE: begin
						m_addr  = addr_q;
						m_we    = 1'b1;
						m_wdata = data_q;
					end
					ssfl_pkg::OP_READ: begin
						m_addr = addr_q;
						m_re   = 1'b1;
					end
					ssfl_pkg::OP_FREE:  h_re = free_good;
					default:            h_re = size_good;
				endcase
			end
			ssfl_pkg::ST_FREE_HEAD: begin
				m_addr  = addr_q;
				m_we    = 1'b1;
				m_wdata = '1;
				h_we    = 1'b1;
				h_wdata = addr_q;
			end
			ssfl_pkg::ST_FREE_ZERO: begin
				m_we    = 1'b1;
				m_wdata = (cnt_q == size_q - SIZE_BITS'(1)) ? WORD_BITS'(head_rd) : '0;
			end
			ssfl_pkg::ST_ALLOC_HEAD: begin
				if (head_rd != '0) begin
					if (head_fits) begin
						m_addr = head_rd + ADDR_BITS'(1);
						m_re   = 1'b1;
					end else begin
						h_we = 1'b1;
					end
				end
			end
			ssfl_pkg::ST_ALLOC_LINK: begin
				m_addr  = blk_q;
				m_we    = 1'b1;
				h_we    = 1'b1;
				h_wdata = ADDR_BITS'(word_rd);
			end
			ssfl_pkg::ST_ALLOC_CLR:  m_we = 1'b1;
			ssfl_pkg::ST_ALLOC_SCAN: m_re = cnt_q != '0;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ssfl_pkg::ST_CLEAR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			blk_out_q <= '0;
			hit_q     <= 1'b0;
			fault_q   <= 1'b0;
			rd_out_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ssfl_pkg::ST_CLEAR: begin
					clr_q <= clr_q + CLR_BITS'(1);
					if (clr_q == CLR_BITS'(CLR_LEN - 1)) begin
						state_q <= ssfl_pkg::ST_IDLE;
					end
				end
				ssfl_pkg::ST_IDLE: begin
					if (start) begin
						op_q    <= ssfl_pkg::op_t'(op);
						addr_q  <= address;
						size_q  <= block_size;
						data_q  <= write_data;
						state_q <= ssfl_pkg::ST_EXEC;
					end
				end
				ssfl_pkg::ST_EXEC: begin
					blk_out_q <= '0;
					hit_q     <= 1'b0;
					fault_q   <= 1'b0;
					rd_out_q  <= '0;
					case (op_q)
						ssfl_pkg::OP_WRITE: begin
							done_q  <= 1'b1;
							state_q <= ssfl_pkg::ST_IDLE;
						end
						ssfl_pkg::OP_READ:  state_q <= ssfl_pkg::ST_RD_WAIT;
						ssfl_pkg::OP_FREE: begin
							if (free_good) begin
								state_q <= ssfl_pkg::ST_FREE_HEAD;
							end else begin
								fault_q <= 1'b1;
								done_q  <= 1'b1;
								state_q <= ssfl_pkg::ST_IDLE;
							end
						end
						default: begin
							if (size_good) begin
								state_q <= ssfl_pkg::ST_ALLOC_HEAD;
							end else begin
								fault_q <= 1'b1;
								done_q  <= 1'b1;
								state_q <= ssfl_pkg::ST_IDLE;
							end
						end
					endcase
				end
				ssfl_pkg::ST_RD_WAIT: begin
					rd_out_q <= word_rd;
					done_q   <= 1'b1;
					state_q  <= ssfl_pkg::ST_IDLE;
				end
				ssfl_pkg::ST_FREE_HEAD: begin
					ptr_q   <= addr_q + ADDR_BITS'(1);
					cnt_q   <= size_q - SIZE_BITS'(1);
					state_q <= ssfl_pkg::ST_FREE_ZERO;
				end
				ssfl_pkg::ST_FREE_ZERO: begin
					ptr_q <= ptr_q + ADDR_BITS'(1);
					cnt_q <= cnt_q - SIZE_BITS'(1);
					if (cnt_q == SIZE_BITS'(1)) begin
						done_q  <= 1'b1;
						state_q <= ssfl_pkg::ST_IDLE;
					end
				end
				ssfl_pkg::ST_ALLOC_HEAD: begin
					if (head_rd == '0) begin
						done_q  <= 1'b1;
						state_q <= ssfl_pkg::ST_IDLE;
					end else if (!head_fits) begin
						fault_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ssfl_pkg::ST_IDLE;
					end else begin
						blk_q   <= head_rd;
						ptr_q   <= head_rd + ADDR_BITS'(1);
						state_q <= ssfl_pkg::ST_ALLOC_LINK;
					end
				end
				ssfl_pkg::ST_ALLOC_LINK: state_q <= ssfl_pkg::ST_ALLOC_CLR;
				ssfl_pkg::ST_ALLOC_CLR: begin
					ptr_q   <= ptr_q + ADDR_BITS'(1);
					cnt_q   <= size_q - SIZE_BITS'(2);
					chk_q   <= 1'b0;
					flt_q   <= 1'b0;
					state_q <= ssfl_pkg::ST_ALLOC_SCAN;
				end
				ssfl_pkg::ST_ALLOC_SCAN: begin
					if (scan_flt) begin
						flt_q <= 1'b1;
					end
					if (cnt_q == '0) begin
						blk_out_q <= blk_q;
						hit_q     <= 1'b1;
						fault_q   <= flt_q | scan_flt;
						done_q    <= 1'b1;
						state_q   <= ssfl_pkg::ST_IDLE;
					end else begin
						ptr_q <= ptr_q + ADDR_BITS'(1);
						cnt_q <= cnt_q - SIZE_BITS'(1);
						chk_q <= 1'b1;
					end
				end
				default: state_q <= ssfl_pkg::ST_IDLE;
			endcase
		end
	end

	assign busy          = state_q != ssfl_pkg::ST_IDLE;
	assign done          = done_q;
	assign block_address = blk_out_q;
	assign hit           = hit_q;
	assign fault         = fault_q;
	assign read_data     = rd_out_q;

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ASSERT_NEXT(a_done_single, done, !done)
	`ASSERT_IMP(a_hit_nonzero, done && hit, block_address != '0)
	`ASSERT_IMP(a_hit_no_rdata, done && hit, read_data == '0)

endmodule
